// ===== src/sprq_pkg.sv =====
// sprq_pkg: shared codes and widths for the stroke point store radius query core.
// No dependencies.
`default_nettype none

package sprq_pkg;

	localparam int IDX_W = 6;   // width of the hit_index port
	localparam int RAD_W = 15;  // width of the radius port
	localparam int R2_W  = 2 * RAD_W;

	typedef enum logic [1:0] {
		FUNC_START  = 2'd0,
		FUNC_APPEND = 2'd1,
		FUNC_QUERY  = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

endpackage

`default_nettype wire

// ===== src/stroke_point_store_radius_query_core.sv =====
// stroke_point_store_radius_query_core: point store of one stroke with bounding box and
// fixed-radius eraser query. Point store is an internal synchronous RAM.
// Depends on sprq_pkg.
`default_nettype none

// Timing: start, append and an undefined func give their single result beat registered at
// the accept edge, as does a query that misses the grown box or hits an empty store.
// A query inside the box scans the store with busy high: the single RAM read port reads
// one point a cycle, and each point passes the difference and square registers to the
// sum-and-compare; a final beat closes the run. Hit beats stream out as matches are found.
// Reset clears the point count, the box and all control; RAM contents are left as is.
module stroke_point_store_radius_query_core
	import sprq_pkg::*;
#(
	parameter int MAX_POINTS = 64,
	parameter int COORD_BITS = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic [1:0]               func,
	input  wire logic signed [15:0]       px,
	input  wire logic signed [15:0]       py,
	input  wire logic [RAD_W-1:0]         radius,
	output logic                          done,
	output logic                          status,
	output logic                          hit,
	output logic [IDX_W-1:0]              hit_index,
	output logic                          last
);

	localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW   = $clog2(MAX_POINTS + 1);
	localparam int CB   = COORD_BITS;
	localparam int DW   = CB + 1;                        // coordinate difference
	localparam int SQW  = 2 * CB;                        // one square
	localparam int SUMW = 2 * CB + 1;                    // sum of squares
	localparam int CMPW = (SUMW > R2_W) ? SUMW : R2_W;   // distance compare width
	localparam int BW   = ((CB > 16) ? CB : 16) + 2;     // box-plus-radius width

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;

	// Coordinates at the configured width: sign-extend or wrap the 16-bit fields.
	logic signed [CB-1:0] x_in, y_in;
	assign x_in = CB'(px);
	assign y_in = CB'(py);

	logic [1:0] state_q;
	logic       accept;
	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// Stroke state
	logic [CW-1:0]        count_q;
	logic signed [CB-1:0] box_left_q, box_right_q, box_top_q, box_bottom_q;

	// Point store RAM: {x, y} per entry, one write and one registered read port
	logic [2*CB-1:0] mem [MAX_POINTS];
	logic [2*CB-1:0] rdata_q;
	logic [AW-1:0]   rd_addr;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;

	// Query context
	logic signed [CB-1:0] qx_q, qy_q;
	logic [R2_W-1:0]      r2_q;
	logic [CW-1:0]        addr_q;
	logic                 issue;

	// Distance pipeline
	logic                 v_s1, v_s2, v_s3;
	logic [AW-1:0]        idx_s1, idx_s2, idx_s3;
	logic signed [DW-1:0] dx_s2, dy_s2;
	logic [SQW-1:0]       dx2_s3, dy2_s3;
	logic                 match;

	// Pending hit: held back until the next match or scan end decides its last flag
	logic                 pend_v_q;
	logic [AW-1:0]        pend_idx_q;

	// Output beat
	logic                 done_q, status_q, hit_q, last_q;
	logic [AW-1:0]        idx_q;

	assign done      = done_q;
	assign status    = status_q;
	assign hit       = hit_q;
	assign hit_index = IDX_W'(idx_q);
	assign last      = last_q;

	// Append decode
	logic full, empty;
	assign empty = (count_q == '0);
	assign full  = (count_q >= CW'(MAX_POINTS));

	// Box test against the box grown by the radius, edges inclusive
	logic signed [BW-1:0] r_ext, xb, yb;
	logic                 outside;
	assign r_ext   = BW'($signed({1'b0, radius}));
	assign xb      = BW'(x_in);
	assign yb      = BW'(y_in);
	assign outside = (xb < BW'(box_left_q) - r_ext) || (xb > BW'(box_right_q) + r_ext)
		|| (yb < BW'(box_top_q) - r_ext) || (yb > BW'(box_bottom_q) + r_ext);

	// RAM write on start / append, read address from the scan counter
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		if (accept) begin
			case (func)
				FUNC_START: begin
					wr_en = 1'b1;
				end
				FUNC_APPEND: begin
					wr_en   = !full;
					wr_addr = empty ? '0 : count_q[AW-1:0];
				end
				default: begin
					wr_en = 1'b0;
				end
			endcase
		end
	end

	assign rd_addr = addr_q[AW-1:0];
	assign issue   = (state_q == ST_SCAN) && (addr_q < count_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {x_in, y_in};
		end
		rdata_q <= mem[rd_addr];
	end

	// Distance datapath: difference, square, then sum-and-compare
	logic [CMPW-1:0] dist2;
	assign dist2 = CMPW'(dx2_s3) + CMPW'(dy2_s3);
	assign match = v_s3 && (dist2 < CMPW'(r2_q));

	always_ff @(posedge clk) begin
		idx_s1 <= rd_addr;
		dx_s2  <= DW'(qx_q) - DW'($signed(rdata_q[2*CB-1:CB]));
		dy_s2  <= DW'(qy_q) - DW'($signed(rdata_q[CB-1:0]));
		idx_s2 <= idx_s1;
		// operands sign-extended to full width so the square is never truncated
		dx2_s3 <= SQW'(dx_s2) * SQW'(dx_s2);
		dy2_s3 <= SQW'(dy_s2) * SQW'(dy_s2);
		idx_s3 <= idx_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Control, stroke state and output beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			box_left_q   <= '0;
			box_right_q  <= '0;
			box_top_q    <= '0;
			box_bottom_q <= '0;
			addr_q       <= '0;
			pend_v_q     <= 1'b0;
			done_q       <= 1'b0;
			status_q     <= 1'b0;
			hit_q        <= 1'b0;
			idx_q        <= '0;
			last_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						done_q   <= 1'b1;
						status_q <= 1'b0;
						hit_q    <= 1'b0;
						idx_q    <= '0;
						last_q   <= 1'b1;
						case (func)
							FUNC_START: begin
								count_q      <= CW'(1);
								box_left_q   <= x_in;
								box_right_q  <= x_in;
								box_top_q    <= y_in;
								box_bottom_q <= y_in;
							end
							FUNC_APPEND: begin
								if (empty) begin
									count_q      <= CW'(1);
									box_left_q   <= x_in;
									box_right_q  <= x_in;
									box_top_q    <= y_in;
									box_bottom_q <= y_in;
								end else if (full) begin
									status_q <= 1'b1;
								end else begin
									count_q <= count_q + CW'(1);
									if (x_in < box_left_q) begin
										box_left_q <= x_in;
									end else if (x_in > box_right_q) begin
										box_right_q <= x_in;
									end
									if (y_in < box_top_q) begin
										box_top_q <= y_in;
									end else if (y_in > box_bottom_q) begin
										box_bottom_q <= y_in;
									end
								end
							end
							FUNC_QUERY: begin
								if (!empty && !outside) begin
									// no beat now: the scan reports
									done_q   <= 1'b0;
									state_q  <= ST_SCAN;
									addr_q   <= '0;
									pend_v_q <= 1'b0;
								end
							end
							default: begin
								status_q <= 1'b0;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (issue) begin
						addr_q <= addr_q + CW'(1);
					end
					if (match) begin
						if (pend_v_q) begin
							done_q   <= 1'b1;
							status_q <= 1'b0;
							hit_q    <= 1'b1;
							idx_q    <= pend_idx_q;
							last_q   <= 1'b0;
						end
						pend_v_q <= 1'b1;
					end else if (!issue && !v_s1 && !v_s2 && !v_s3) begin
						// scan drained: close the run
						done_q   <= 1'b1;
						status_q <= 1'b0;
						hit_q    <= pend_v_q;
						idx_q    <= pend_v_q ? pend_idx_q : '0;
						last_q   <= 1'b1;
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Query operands and pending index carry no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			qx_q <= x_in;
			qy_q <= y_in;
			r2_q <= R2_W'(radius) * R2_W'(radius);
		end
		if (match) begin
			pend_idx_q <= idx_s3;
		end
	end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// testbench: self-checking bench for stroke_point_store_radius_query_core.
// Queued start/busy commands, a shadow point store predicting every done beat.
// Depends on sprq_pkg and stroke_point_store_radius_query_core.
module testbench;
	import sprq_pkg::*;

	localparam int MAX_POINTS   = 64;
	localparam int COORD_BITS   = 16;
	localparam int QUIET_LIMIT  = 2000; // cycles with no beat either way before giving up
	localparam int DRAIN_CYCLES = 80;   // idle stretch after the last prediction to catch stray beats
	localparam int RANDOM_ITEMS = 300;
	localparam int CALM_TAIL    = 60;   // last stretch of random items runs back to back

	// one command beat, plus how it is to be issued
	typedef struct packed {
		func_t              fn;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [RAD_W-1:0]   r;
		logic [2:0]         gap;        // idle cycles before start is raised
		logic               wait_empty; // hold off until every pending result is out
	} cmd_t;

	// one result beat
	typedef struct packed {
		logic             status;
		logic             hit;
		logic [IDX_W-1:0] idx;
		logic             last;
	} beat_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic [1:0]               func = FUNC_START;
	logic signed [15:0]       px = '0;
	logic signed [15:0]       py = '0;
	logic [RAD_W-1:0]         radius = '0;
	logic                     busy;
	logic                     done;
	logic                     status;
	logic                     hit;
	logic [IDX_W-1:0]         hit_index;
	logic                     last;

	stroke_point_store_radius_query_core #(
		.MAX_POINTS(MAX_POINTS),
		.COORD_BITS(COORD_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.px(px),
		.py(py),
		.radius(radius),
		.done(done),
		.status(status),
		.hit(hit),
		.hit_index(hit_index),
		.last(last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow copy of the stroke: points and bounding box
	int stroke_x [MAX_POINTS];
	int stroke_y [MAX_POINTS];
	int n_points = 0;
	int box_left = 0;
	int box_right = 0;
	int box_top = 0;
	int box_bottom = 0;

	cmd_t  cmd_q[$];    // commands still to be issued
	beat_t beat_q[$];   // result beats predicted but not yet seen
	int    n_total = 0;
	int    n_sent = 0;
	int    n_errors = 0;

	// stimulus shaping
	bit gaps_on = 1'b1;
	int path_x[$];      // points of the stroke being generated, for aiming queries
	int path_y[$];

	task automatic open_stroke(input int x, input int y);
		stroke_x[0] = x;
		stroke_y[0] = y;
		n_points = 1;
		box_left = x;
		box_right = x;
		box_top = y;
		box_bottom = y;
	endtask

	// Advance the shadow store by one command and queue the beats it must cause.
	task automatic predict_beats(input cmd_t c);
		int xi, yi, ri, dx, dy;
		longint r2, d2;
		bit have;
		beat_t b, pend;
		xi = int'(c.x);
		yi = int'(c.y);
		ri = int'(c.r);
		b = '0;
		b.last = 1'b1;
		pend = '0;
		have = 1'b0;
		case (c.fn)
			FUNC_START: begin
				open_stroke(xi, yi);
			end
			FUNC_APPEND: begin
				if (n_points == 0) begin
					// append to an empty store opens a stroke
					open_stroke(xi, yi);
				end else if (n_points >= MAX_POINTS) begin
					// full: point dropped, box untouched
					b.status = 1'b1;
				end else begin
					if (xi < box_left) box_left = xi;
					else if (xi > box_right) box_right = xi;
					if (yi < box_top) box_top = yi;
					else if (yi > box_bottom) box_bottom = yi;
					stroke_x[n_points] = xi;
					stroke_y[n_points] = yi;
					n_points++;
				end
			end
			FUNC_QUERY: begin
				// box grown by the radius, edges inclusive; empty store never scans
				if (n_points != 0 && xi >= box_left - ri && xi <= box_right + ri &&
						yi >= box_top - ri && yi <= box_bottom + ri) begin
					r2 = longint'(ri) * longint'(ri);
					for (int i = 0; i < n_points; i++) begin
						dx = xi - stroke_x[i];
						dy = yi - stroke_y[i];
						d2 = longint'(dx) * longint'(dx) + longint'(dy) * longint'(dy);
						if (d2 < r2) begin
							// a hit is held back one step so the final one can carry last
							if (have) beat_q.push_back(pend);
							pend = '0;
							pend.hit = 1'b1;
							pend.idx = IDX_W'(i);
							have = 1'b1;
						end
					end
					if (have) begin
						pend.last = 1'b1;
						b = pend;
					end
				end
			end
			default: begin
				// undefined selector: nothing changes
			end
		endcase
		beat_q.push_back(b);
	endtask

	task automatic push_cmd(input func_t fn, input int x, input int y, input int r,
			input bit wait_empty);
		cmd_t c;
		c.fn = fn;
		c.x = x[15:0];
		c.y = y[15:0];
		c.r = r[RAD_W-1:0];
		c.wait_empty = wait_empty;
		c.gap = (gaps_on && $urandom_range(0, 2) == 0) ? 3'($urandom_range(1, 5)) : 3'd0;
		cmd_q.push_back(c);
	endtask

	// query near one point of the stroke being generated
	task automatic aim_query();
		int j, rad;
		j = $urandom_range(0, path_x.size() - 1);
		case ($urandom_range(0, 5))
			0: rad = 0;
			1: rad = $urandom_range(0, 32767);
			2: rad = 32767;
			default: rad = $urandom_range(1, 120);
		endcase
		push_cmd(FUNC_QUERY, path_x[j] + int'($urandom_range(0, 80)) - 40,
			path_y[j] + int'($urandom_range(0, 80)) - 40, rad, 1'b0);
	endtask

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
			n_errors++;
		end
	endtask

	// Driver: one command beat in flight on the ports; the next one is staged
	// behind it with its own idle gap. A beat moves when start is high and busy low.
	cmd_t cur;
	cmd_t staged;
	bit   have_staged;
	int   idle_left;

	always @(posedge clk or negedge arst_n) begin
		logic start_n;
		if (!arst_n) begin
			start <= 1'b0;
			have_staged = 1'b0;
			idle_left = 0;
		end else begin
			start_n = start;
			if (start && !busy) begin
				predict_beats(cur);
				n_sent++;
				start_n = 1'b0;
			end
			if (!start_n) begin
				if (!have_staged && cmd_q.size() > 0) begin
					staged = cmd_q.pop_front();
					have_staged = 1'b1;
					idle_left = staged.gap;
				end
				if (have_staged) begin
					if (idle_left > 0) begin
						idle_left--;
					end else if (!staged.wait_empty || beat_q.size() == 0) begin
						cur = staged;
						have_staged = 1'b0;
						start_n = 1'b1;
						func <= staged.fn;
						px <= staged.x;
						py <= staged.y;
						radius <= staged.r;
					end
				end
			end
			// single write per edge, so back-to-back beats keep start high
			start <= start_n;
		end
	end

	// Monitor: done marks a result beat for exactly one cycle; compare it with
	// the oldest prediction. Watchdog counts cycles where no beat moves at all.
	int quiet = 0;

	always @(posedge clk) begin
		beat_t want;
		if (arst_n) begin
			if (done) begin
				if (beat_q.size() == 0) begin
					$display("%0t: unexpected result beat, expected none actual %0b/%0b/%0d/%0b",
						$time, status, hit, hit_index, last);
					n_errors++;
				end else begin
					want = beat_q.pop_front();
					check_field("status", want.status, status);
					check_field("hit", want.hit, hit);
					check_field("hit_index", want.idx, hit_index);
					check_field("last", want.last, last);
				end
			end
			if (done || (start && !busy)) quiet = 0;
			else quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("%0t: watchdog, no beat for %0d cycles", $time, QUIET_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		int base, n, kind, cx, cy;
		bit first, hold, long_run;

		// directed: empty store, append-to-empty, undefined selector
		push_cmd(FUNC_QUERY, 5, 5, 100, 1'b0);
		push_cmd(FUNC_APPEND, 100, -50, 0, 1'b0);
		push_cmd(FUNC_QUERY, 100, -50, 1, 1'b0);
		push_cmd(FUNC_NONE, -1, -1, 32767, 1'b0);
		push_cmd(FUNC_QUERY, 100, -50, 0, 1'b0);   // zero radius never matches
		// coordinate extremes, box spans the full range
		push_cmd(FUNC_START, -32768, 32767, 0, 1'b0);
		push_cmd(FUNC_APPEND, 32767, -32768, 32767, 1'b0);
		push_cmd(FUNC_APPEND, 0, 0, 0, 1'b0);
		push_cmd(FUNC_QUERY, 0, 0, 32767, 1'b0);
		push_cmd(FUNC_QUERY, -32768, 32767, 32767, 1'b0);
		push_cmd(FUNC_QUERY, 32767, 32767, 0, 1'b0);
		// strict distance compare and inclusive box edges
		push_cmd(FUNC_START, 0, 0, 0, 1'b1);
		push_cmd(FUNC_APPEND, 3, 4, 0, 1'b0);
		push_cmd(FUNC_QUERY, 0, 0, 5, 1'b0);
		push_cmd(FUNC_QUERY, 0, 0, 6, 1'b0);
		push_cmd(FUNC_QUERY, 9, 4, 6, 1'b0);       // on the grown edge, no point close enough
		push_cmd(FUNC_QUERY, 10, 4, 6, 1'b0);      // just outside the grown box
		push_cmd(FUNC_QUERY, -6, -6, 6, 1'b0);
		push_cmd(FUNC_APPEND, -10, -10, 0, 1'b0);
		push_cmd(FUNC_QUERY, -10, -10, 1, 1'b0);
		push_cmd(FUNC_NONE, 0, 0, 0, 1'b0);
		push_cmd(FUNC_QUERY, 32767, -32768, 32767, 1'b0);

		// random: mostly stroke-shaped sequences, some noise and broken ones
		base = cmd_q.size();
		first = 1'b1;
		while (cmd_q.size() - base < RANDOM_ITEMS) begin
			gaps_on = (cmd_q.size() - base < RANDOM_ITEMS - CALM_TAIL) &&
				$urandom_range(0, 3) != 0;
			hold = first || $urandom_range(0, 4) == 0;
			kind = first ? 1 : $urandom_range(0, 9);
			if (kind == 0 || kind == 9) begin
				n = $urandom_range(1, 4);
				for (int k = 0; k < n; k++)
					push_cmd(func_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
						hold && k == 0);
			end else begin
				cx = int'($urandom_range(0, 65535)) - 32768;
				cy = int'($urandom_range(0, 65535)) - 32768;
				long_run = first || (kind == 8 && $urandom_range(0, 1) == 0);
				n = long_run ? $urandom_range(64, 70) : $urandom_range(1, 12);
				path_x.delete();
				path_y.delete();
				push_cmd(FUNC_START, cx, cy, $urandom, hold);
				path_x.push_back(cx);
				path_y.push_back(cy);
				for (int k = 0; k < n; k++) begin
					cx += int'($urandom_range(0, 64)) - 32;
					cy += int'($urandom_range(0, 64)) - 32;
					push_cmd(FUNC_APPEND, cx, cy, $urandom, 1'b0);
					path_x.push_back(cx);
					path_y.push_back(cy);
					if ($urandom_range(0, 6) == 0) aim_query();
				end
				// wide eraser over a full stroke: every point hits
				if (long_run) push_cmd(FUNC_QUERY, cx, cy, 32767, 1'b0);
				n = $urandom_range(1, 4);
				for (int k = 0; k < n; k++) aim_query();
			end
			first = 1'b0;
		end
		n_total = cmd_q.size();

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (n_sent < n_total || beat_q.size() != 0) @(posedge clk);
		// stray beats after the last prediction still get flagged here
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== stroke_point_store_radius_query_core.f =====
src/sprq_pkg.sv
src/stroke_point_store_radius_query_core.sv
dv/testbench.sv
